// File: rtl/lbbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbbf_pkg
// types and constants shared by the length-bucketed batch former
// ----------------------------------------------------------------------------
package lbbf_pkg;

  typedef enum logic [1:0] {
    ACT_ENQ = 2'd0,
    ACT_END = 2'd1,
    ACT_GEN = 2'd2,
    ACT_CLR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_ENQUEUED    = 3'd0,
    STS_SKIPPED     = 3'd1,
    STS_REJECTED    = 3'd2,
    STS_MEMBER      = 3'd3,
    STS_EMPTY       = 3'd4,
    STS_SUBMIT_DONE = 3'd5,
    STS_CLEARED     = 3'd6
  } status_t;

  typedef enum logic {
    REG_MBW    = 1'b0,
    REG_MAXTOK = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ALU_FIT = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  // one pooled sentence
  typedef struct packed {
    logic [7:0]  tokens;
    logic [11:0] segment;
    logic [15:0] request;
  } entry_t;

  typedef struct packed {
    alu_op_t     op;
    logic [6:0]  count;
    logic [11:0] len;
    logic [15:0] budget;
    logic [8:0]  rem;
    logic [7:0]  divisor;
  } alu_req_t;

  typedef struct packed {
    logic       over;
    logic       ge;
    logic [7:0] diff;
  } alu_rsp_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] request;
    logic [11:0] segment;
    logic [7:0]  tokens;
    logic        last;
    logic [10:0] cap;
    logic [10:0] batches;
    logic [10:0] pending;
  } out_item_t;

  localparam int FRESH_W = 20;
  localparam int DIV_W   = 21;
  localparam int SAT11   = 2047;

  localparam logic [15:0] MBW_RESET    = 16'd1024;
  localparam logic [7:0]  MAXTOK_RESET = 8'd255;

endpackage
`default_nettype wire

// File: rtl/lbbf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbbf_in_if
// request channel of the batch former
// ----------------------------------------------------------------------------
interface lbbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] request_id;
  logic [11:0] segment_index;
  logic [11:0] token_count;
  logic        cache_hit;
  logic [7:0]  worker_count;

  modport source (
    output valid, action, request_id, segment_index, token_count, cache_hit,
           worker_count,
    input  ready
  );
  modport sink (
    input  valid, action, request_id, segment_index, token_count, cache_hit,
           worker_count,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/lbbf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbbf_out_if
// result channel of the batch former
// ----------------------------------------------------------------------------
interface lbbf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_request;
  logic [11:0] out_segment;
  logic [7:0]  out_tokens;
  logic        last;
  logic [10:0] sentence_cap;
  logic [10:0] batch_count;
  logic [10:0] pending_total;

  modport source (
    output valid, status, out_request, out_segment, out_tokens, last,
           sentence_cap, batch_count, pending_total,
    input  ready
  );
  modport sink (
    input  valid, status, out_request, out_segment, out_tokens, last,
           sentence_cap, batch_count, pending_total,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/lbbf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbbf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lbbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/lbbf_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbbf_alu
// shared budget-fit multiply/compare and divider trial subtract
// ----------------------------------------------------------------------------
module lbbf_alu (
  input  lbbf_pkg::alu_req_t req,
  output lbbf_pkg::alu_rsp_t rsp
);

  logic [19:0] prod;
  logic [8:0]  dvs9;

  always_comb begin
    // padded words if one more sentence of this length joins
    prod     = (20'(req.count) + 20'd1) * 20'(req.len);
    dvs9     = {1'b0, req.divisor};
    rsp.over = (req.op == lbbf_pkg::ALU_FIT) && (prod > 20'(req.budget));
    rsp.ge   = (req.op == lbbf_pkg::ALU_DIV) && (req.rem >= dvs9);
    rsp.diff = 8'(req.rem - dvs9);
  end

endmodule
`default_nettype wire

// File: rtl/length_bucketed_batch_former.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_bucketed_batch_former
// pools sentences in per-length fifo buckets and forms padded batches
// ----------------------------------------------------------------------------
// usage
//   in_chan carries one command per transfer: enqueue, end submission,
//   generate batch or clear. out_chan returns the results; every command
//   gives one result except generate, which gives one per batch member
//   (last marks the final one) or a single empty-batch result.
//   the apb port holds mini_batch_words (addr 0) and max_tokens (addr 4).
// sequencing
//   one command at a time; in_chan.ready is high only between commands.
//   enqueue, skip, reject pass through S_ENQ to the result register; clear
//   goes straight to it. end submission scans lengths up to the longest
//   active one, walks every pooled sentence, then runs the divider for a cap.
//   generate scans lengths and takes members, then emits one result per
//   member; the linked-list ram read latency shapes these steps.
// reset and stalls
//   rst_n empties the pool at once (bucket valid bits, fill count); no
//   clearing pass. a stalled receiver holds the result register and the
//   sequencer waits; the next command is taken once its result is loaded.
// ----------------------------------------------------------------------------
module length_bucketed_batch_former #(
  parameter int MAX_LENGTH_BUCKETS = 256,
  parameter int POOL_DEPTH         = 1024,
  parameter int MAX_BATCH          = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  lbbf_in_if.sink     in_chan,
  lbbf_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int LW = $clog2(MAX_LENGTH_BUCKETS);
  localparam int NW = $clog2(MAX_BATCH + 1);
  localparam int BW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int EW = $bits(lbbf_pkg::entry_t);
  localparam int FW = lbbf_pkg::FRESH_W;
  localparam int DW = lbbf_pkg::DIV_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ENQ, S_CNT_LEN, S_CNT_RD, S_CNT_ENT, S_CNT_LINK, S_CNT_END,
    S_DIV, S_GEN_LEN, S_GEN_RD, S_GEN_ENT, S_GEN_CHK, S_GEN_END,
    S_EMIT_RD, S_EMIT, S_RESP
  } state_t;

  // sequencer and pool bookkeeping
  state_t                state_r, state_nxt;
  logic [15:0]           mbw_r, mbw_nxt;
  logic [7:0]            maxtok_r, maxtok_nxt;
  logic [MAX_LENGTH_BUCKETS-1:0] ne_r, ne_nxt;
  logic [PW-1:0]         free_head_r, free_head_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [CW-1:0]         pending_r, pending_nxt;
  logic [FW-1:0]         fresh_r, fresh_nxt;
  logic [10:0]           cap_r, cap_nxt;
  logic [LW-1:0]         maxlen_r, maxlen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lbbf_pkg::out_item_t   out_r, out_nxt;

  // walk and command payload
  logic [LW-1:0]         len_r, len_nxt;
  logic [PW-1:0]         e_r, e_nxt;
  logic [PW-1:0]         tail_r, tail_nxt;
  logic [NW-1:0]         n_r, n_nxt;
  logic [NW-1:0]         k_r, k_nxt;
  logic [NW-1:0]         inb_r, inb_nxt;
  logic [CW-1:0]         batches_r, batches_nxt;
  logic [15:0]           req_r, req_nxt;
  logic [11:0]           seg_r, seg_nxt;
  logic [11:0]           tok_r, tok_nxt;
  logic                  hit_r, hit_nxt;
  logic [7:0]            wrk_r, wrk_nxt;
  lbbf_pkg::status_t     rsp_status_r, rsp_status_nxt;
  logic [7:0]            div_rem_r, div_rem_nxt;
  logic [DW-1:0]         div_num_r, div_num_nxt;
  logic [4:0]            div_cnt_r, div_cnt_nxt;

  // ram ports
  logic                  head_we, tail_we, link_we, entry_we, rbuf_we;
  logic [LW-1:0]         head_waddr, tail_waddr, tail_raddr;
  logic [PW-1:0]         head_wdata, tail_wdata, head_rdata, tail_rdata;
  logic [PW-1:0]         link_waddr, link_wdata, link_raddr, link_rdata;
  logic [PW-1:0]         entry_waddr, entry_raddr;
  lbbf_pkg::entry_t      entry_wdata, entry_rd, rbuf_rd;

  lbbf_pkg::alu_req_t    alu_req;
  lbbf_pkg::alu_rsp_t    alu_rsp;

  // helpers
  logic                  out_free, in_xfer, cfg_wr, reject, cut;
  logic [PW-1:0]         alloc_e;
  logic [NW-1:0]         n_inc;
  logic [CW-1:0]         batches_f;
  logic [7:0]            w_eff;
  logic [DW-1:0]         quot;
  logic [8:0]            div_trial;
  logic [10:0]           pend_sat, batch_sat;

  lbbf_ram #(.WIDTH(PW), .DEPTH(MAX_LENGTH_BUCKETS)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(len_r), .rdata(head_rdata)
  );

  lbbf_ram #(.WIDTH(PW), .DEPTH(MAX_LENGTH_BUCKETS)) u_tail_ram (
    .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
    .raddr(tail_raddr), .rdata(tail_rdata)
  );

  lbbf_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  lbbf_ram #(.WIDTH(EW), .DEPTH(POOL_DEPTH)) u_entry_ram (
    .clk(clk), .we(entry_we), .waddr(entry_waddr), .wdata(entry_wdata),
    .raddr(entry_raddr), .rdata(entry_rd)
  );

  // members of the batch being formed wait here for the final cap/pending
  lbbf_ram #(.WIDTH(EW), .DEPTH(MAX_BATCH)) u_rbuf_ram (
    .clk(clk), .we(rbuf_we), .waddr(BW'(n_r)), .wdata(entry_rd),
    .raddr(BW'(k_r)), .rdata(rbuf_rd)
  );

  lbbf_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  // apb side
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == lbbf_pkg::REG_MAXTOK) ? {24'd0, maxtok_r}
                                                      : {16'd0, mbw_r};

  // channel side
  assign in_chan.ready          = (state_r == S_IDLE);
  assign in_xfer                = in_chan.valid & in_chan.ready;
  assign out_free               = !out_valid_r || out_chan.ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_r.status;
  assign out_chan.out_request   = out_r.request;
  assign out_chan.out_segment   = out_r.segment;
  assign out_chan.out_tokens    = out_r.tokens;
  assign out_chan.last          = out_r.last;
  assign out_chan.sentence_cap  = out_r.cap;
  assign out_chan.batch_count   = out_r.batches;
  assign out_chan.pending_total = out_r.pending;

  always_comb begin
    pend_sat  = (32'(pending_r) > 32'(lbbf_pkg::SAT11)) ? 11'(lbbf_pkg::SAT11)
                                                         : 11'(pending_r);
    batch_sat = (32'(batches_r) > 32'(lbbf_pkg::SAT11)) ? 11'(lbbf_pkg::SAT11)
                                                         : 11'(batches_r);
    // recycled entries first, then never-used ones
    alloc_e   = (pending_r < fill_r) ? free_head_r : PW'(fill_r);
    reject    = ({1'b0, tok_r} > {5'd0, maxtok_r}) ||
                ({1'b0, tok_r} >= 13'(MAX_LENGTH_BUCKETS)) ||
                (pending_r >= CW'(POOL_DEPTH));
    n_inc     = n_r + NW'(1);
    cut       = (inb_r != '0) && (alu_rsp.over || (inb_r >= NW'(MAX_BATCH)));
    batches_f = batches_r + CW'(inb_r != '0);
    w_eff     = (wrk_r == 8'd0) ? 8'd1 : wrk_r;
    div_trial = {div_rem_r, div_num_r[DW-1]};
    quot      = {div_num_r[DW-2:0], alu_rsp.ge};
  end

  // shared unit operands
  always_comb begin
    alu_req.op      = (state_r == S_DIV) ? lbbf_pkg::ALU_DIV : lbbf_pkg::ALU_FIT;
    alu_req.count   = (state_r == S_CNT_ENT) ? 7'(inb_r) : 7'(n_r);
    alu_req.len     = 12'(len_r);
    alu_req.budget  = mbw_r;
    alu_req.rem     = div_trial;
    alu_req.divisor = w_eff;
  end

  always_comb begin
    state_nxt      = state_r;
    mbw_nxt        = mbw_r;
    maxtok_nxt     = maxtok_r;
    ne_nxt         = ne_r;
    free_head_nxt  = free_head_r;
    fill_nxt       = fill_r;
    pending_nxt    = pending_r;
    fresh_nxt      = fresh_r;
    cap_nxt        = cap_r;
    maxlen_nxt     = maxlen_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_nxt        = out_r;
    len_nxt        = len_r;
    e_nxt          = e_r;
    tail_nxt       = tail_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    inb_nxt        = inb_r;
    batches_nxt    = batches_r;
    req_nxt        = req_r;
    seg_nxt        = seg_r;
    tok_nxt        = tok_r;
    hit_nxt        = hit_r;
    wrk_nxt        = wrk_r;
    rsp_status_nxt = rsp_status_r;
    div_rem_nxt    = div_rem_r;
    div_num_nxt    = div_num_r;
    div_cnt_nxt    = div_cnt_r;

    head_we     = 1'b0;
    head_waddr  = len_r;
    head_wdata  = link_rdata;
    tail_we     = 1'b0;
    tail_waddr  = tok_r[LW-1:0];
    tail_wdata  = alloc_e;
    tail_raddr  = len_r;
    link_we     = 1'b0;
    link_waddr  = e_r;
    link_wdata  = free_head_r;
    link_raddr  = e_r;
    entry_we    = 1'b0;
    entry_waddr = alloc_e;
    entry_wdata = '{tokens: tok_r[7:0], segment: seg_r, request: req_r};
    entry_raddr = e_r;
    rbuf_we     = 1'b0;

    if (cfg_wr) begin
      if (paddr[2] == lbbf_pkg::REG_MBW) begin
        mbw_nxt = pwdata[15:0];
      end else begin
        maxtok_nxt = pwdata[7:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        // prefetch free-list link and bucket tail for an enqueue
        tail_raddr = in_chan.token_count[LW-1:0];
        link_raddr = free_head_r;
        if (in_xfer) begin
          req_nxt     = in_chan.request_id;
          seg_nxt     = in_chan.segment_index;
          tok_nxt     = in_chan.token_count;
          hit_nxt     = in_chan.cache_hit;
          wrk_nxt     = in_chan.worker_count;
          len_nxt     = '0;
          n_nxt       = '0;
          inb_nxt     = '0;
          batches_nxt = '0;
          case (lbbf_pkg::action_t'(in_chan.action))
            lbbf_pkg::ACT_ENQ: state_nxt = S_ENQ;
            lbbf_pkg::ACT_END: state_nxt = S_CNT_LEN;
            lbbf_pkg::ACT_GEN: state_nxt = S_GEN_LEN;
            default: begin
              ne_nxt         = '0;
              free_head_nxt  = '0;
              fill_nxt       = '0;
              pending_nxt    = '0;
              fresh_nxt      = '0;
              cap_nxt        = '0;
              maxlen_nxt     = '0;
              rsp_status_nxt = lbbf_pkg::STS_CLEARED;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end

      S_ENQ: begin
        state_nxt = S_RESP;
        if (hit_r) begin
          rsp_status_nxt = lbbf_pkg::STS_SKIPPED;
        end else if (reject) begin
          rsp_status_nxt = lbbf_pkg::STS_REJECTED;
        end else begin
          rsp_status_nxt = lbbf_pkg::STS_ENQUEUED;
          entry_we = 1'b1;
          tail_we  = 1'b1;
          if (ne_r[tok_r[LW-1:0]]) begin
            // append behind the current tail
            link_we    = 1'b1;
            link_waddr = tail_rdata;
            link_wdata = alloc_e;
          end else begin
            head_we    = 1'b1;
            head_waddr = tok_r[LW-1:0];
            head_wdata = alloc_e;
            ne_nxt[tok_r[LW-1:0]] = 1'b1;
          end
          if (pending_r < fill_r) begin
            free_head_nxt = link_rdata;
          end else begin
            fill_nxt = fill_r + CW'(1);
          end
          if (tok_r[LW-1:0] > maxlen_r) begin
            maxlen_nxt = tok_r[LW-1:0];
          end
          pending_nxt = pending_r + CW'(1);
          if (fresh_r != '1) begin
            fresh_nxt = fresh_r + FW'(1);
          end
        end
      end

      // batch count walk
      S_CNT_LEN: begin
        if (ne_r[len_r]) begin
          state_nxt = S_CNT_RD;
        end else if (len_r == maxlen_r) begin
          state_nxt = S_CNT_END;
        end else begin
          len_nxt = len_r + LW'(1);
        end
      end

      S_CNT_RD: begin
        e_nxt     = head_rdata;
        tail_nxt  = tail_rdata;
        state_nxt = S_CNT_ENT;
      end

      S_CNT_ENT: begin
        if (cut) begin
          batches_nxt = batches_r + CW'(1);
          inb_nxt     = NW'(1);
        end else begin
          inb_nxt = inb_r + NW'(1);
        end
        if (e_r == tail_r) begin
          if (len_r == maxlen_r) begin
            state_nxt = S_CNT_END;
          end else begin
            len_nxt   = len_r + LW'(1);
            state_nxt = S_CNT_LEN;
          end
        end else begin
          state_nxt = S_CNT_LINK;
        end
      end

      S_CNT_LINK: begin
        e_nxt     = link_rdata;
        state_nxt = S_CNT_ENT;
      end

      S_CNT_END: begin
        batches_nxt    = batches_f;
        rsp_status_nxt = lbbf_pkg::STS_SUBMIT_DONE;
        if ((fresh_r != '0) && (32'(batches_f) < 32'(w_eff))) begin
          // cap = ceil(fresh / workers), restoring division
          div_num_nxt = DW'(fresh_r) + DW'(w_eff) - DW'(1);
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end else begin
          fresh_nxt = '0;
          state_nxt = S_RESP;
        end
      end

      S_DIV: begin
        div_rem_nxt = alu_rsp.ge ? alu_rsp.diff : div_trial[7:0];
        div_num_nxt = quot;
        div_cnt_nxt = div_cnt_r + 5'd1;
        if (div_cnt_r == 5'(DW - 1)) begin
          cap_nxt   = (32'(quot) > 32'(lbbf_pkg::SAT11)) ? 11'(lbbf_pkg::SAT11)
                                                         : 11'(quot);
          fresh_nxt = '0;
          state_nxt = S_RESP;
        end
      end

      // batch generation walk
      S_GEN_LEN: begin
        if (ne_r[len_r]) begin
          if ((n_r != '0) && alu_rsp.over) begin
            state_nxt = S_GEN_END;
          end else begin
            state_nxt = S_GEN_RD;
          end
        end else if (len_r == maxlen_r) begin
          state_nxt = S_GEN_END;
        end else begin
          len_nxt = len_r + LW'(1);
        end
      end

      S_GEN_RD: begin
        e_nxt       = head_rdata;
        tail_nxt    = tail_rdata;
        entry_raddr = head_rdata;
        link_raddr  = head_rdata;
        state_nxt   = S_GEN_ENT;
      end

      S_GEN_ENT: begin
        // pop the head, return it to the free list, park it in the buffer
        if (e_r == tail_r) begin
          ne_nxt[len_r] = 1'b0;
        end else begin
          head_we = 1'b1;
        end
        link_we       = 1'b1;
        free_head_nxt = e_r;
        pending_nxt   = pending_r - CW'(1);
        rbuf_we       = 1'b1;
        n_nxt         = n_inc;
        if (((cap_r != '0) && (32'(n_inc) >= 32'(cap_r))) ||
            (n_inc >= NW'(MAX_BATCH))) begin
          state_nxt = S_GEN_END;
        end else if (e_r == tail_r) begin
          if (len_r == maxlen_r) begin
            state_nxt = S_GEN_END;
          end else begin
            len_nxt   = len_r + LW'(1);
            state_nxt = S_GEN_LEN;
          end
        end else begin
          e_nxt     = link_rdata;
          state_nxt = S_GEN_CHK;
        end
      end

      S_GEN_CHK: begin
        if (alu_rsp.over) begin
          state_nxt = S_GEN_END;
        end else begin
          state_nxt = S_GEN_ENT;
        end
      end

      S_GEN_END: begin
        if (pending_r == '0) begin
          cap_nxt = '0;
        end
        k_nxt = '0;
        if (n_r == '0) begin
          rsp_status_nxt = lbbf_pkg::STS_EMPTY;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end

      S_EMIT_RD: begin
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_nxt.status  = lbbf_pkg::STS_MEMBER;
          out_nxt.request = rbuf_rd.request;
          out_nxt.segment = rbuf_rd.segment;
          out_nxt.tokens  = rbuf_rd.tokens;
          out_nxt.last    = (k_r + NW'(1) == n_r);
          out_nxt.cap     = cap_r;
          out_nxt.batches = '0;
          out_nxt.pending = pend_sat;
          if (k_r + NW'(1) == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + NW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_nxt.status  = rsp_status_r;
          out_nxt.request = '0;
          out_nxt.segment = '0;
          out_nxt.tokens  = '0;
          out_nxt.last    = 1'b1;
          out_nxt.cap     = cap_r;
          out_nxt.batches = batch_sat;
          out_nxt.pending = pend_sat;
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mbw_r       <= lbbf_pkg::MBW_RESET;
      maxtok_r    <= lbbf_pkg::MAXTOK_RESET;
      ne_r        <= '0;
      free_head_r <= '0;
      fill_r      <= '0;
      pending_r   <= '0;
      fresh_r     <= '0;
      cap_r       <= '0;
      maxlen_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mbw_r       <= mbw_nxt;
      maxtok_r    <= maxtok_nxt;
      ne_r        <= ne_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      pending_r   <= pending_nxt;
      fresh_r     <= fresh_nxt;
      cap_r       <= cap_nxt;
      maxlen_r    <= maxlen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r        <= out_nxt;
    len_r        <= len_nxt;
    e_r          <= e_nxt;
    tail_r       <= tail_nxt;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    inb_r        <= inb_nxt;
    batches_r    <= batches_nxt;
    req_r        <= req_nxt;
    seg_r        <= seg_nxt;
    tok_r        <= tok_nxt;
    hit_r        <= hit_nxt;
    wrk_r        <= wrk_nxt;
    rsp_status_r <= rsp_status_nxt;
    div_rem_r    <= div_rem_nxt;
    div_num_r    <= div_num_nxt;
    div_cnt_r    <= div_cnt_nxt;
  end

  // pool accounting: waiting sentences never outnumber allocated entries
  a_pend_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= fill_r)
    else $error("pending count above fill count");

  a_fill_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(POOL_DEPTH))
    else $error("fill count above pool depth");

  // every live bucket holds at least one sentence
  a_buckets_backed: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ne_r) <= 32'(pending_r))
    else $error("more live buckets than pending sentences");

  // a generate never stores past the result buffer
  a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEN_ENT) |-> (n_r < NW'(MAX_BATCH)))
    else $error("batch member index beyond buffer");

endmodule
`default_nettype wire

// File: tb/sv/tb_length_bucketed_batch_former.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_bucketed_batch_former
// checks the batch former against a behavioural pool kept in the bench:
// directed cases for every command and corner, then random sentence traffic
// with random gaps on both channels and several register settings
// ----------------------------------------------------------------------------
module tb_length_bucketed_batch_former;

  localparam int NBUCK = 256;
  localparam int DEPTH = 1024;
  localparam int MAXB  = 64;
  localparam int LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lbbf_in_if  in_chan ();
  lbbf_out_if out_chan ();

  length_bucketed_batch_former u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // pool model: one fifo queue of sentences per length
  lbbf_pkg::entry_t    buckets[NBUCK][$];
  int unsigned         pool_fill, fresh_cnt, cap_val, max_len;
  int unsigned         budget_words = 1024, tok_limit = 255;
  lbbf_pkg::out_item_t expected_results[$];
  int                  errors = 0;
  int unsigned         cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("%0t timeout", $time);
      $display("tb_length_bucketed_batch_former: done, errors");
      $finish;
    end
  end

  function automatic logic [10:0] sat(int unsigned v);
    return (v > lbbf_pkg::SAT11) ? 11'(lbbf_pkg::SAT11) : 11'(v);
  endfunction

  function automatic lbbf_pkg::out_item_t plain_result(lbbf_pkg::status_t s,
                                                       int unsigned b);
    lbbf_pkg::out_item_t r;
    r = '0;
    r.status  = s;
    r.last    = 1'b1;
    r.cap     = sat(cap_val);
    r.batches = sat(b);
    r.pending = sat(pool_fill);
    return r;
  endfunction

  // batches the pool would form, first sentence of a batch always fits
  function automatic int unsigned count_pool_batches();
    int unsigned nb, inb;
    nb = 0;
    inb = 0;
    for (int l = 0; l < NBUCK && l <= max_len; l++)
      for (int k = 0; k < buckets[l].size(); k++) begin
        if (inb > 0 && ((inb + 1) * l > budget_words || inb >= MAXB)) begin
          nb++;
          inb = 0;
        end
        inb++;
      end
    if (inb > 0) nb++;
    return nb;
  endfunction

  task automatic predict_command(logic [1:0] act, logic [15:0] req, logic [11:0] seg,
                                 logic [11:0] tok, logic hit, logic [7:0] wk);
    lbbf_pkg::out_item_t r;
    lbbf_pkg::entry_t    e;
    int unsigned         nb, w, n;
    bit                  stop;
    lbbf_pkg::out_item_t batch[$];
    case (act)
      lbbf_pkg::ACT_ENQ: begin
        if (hit) expected_results.push_back(plain_result(lbbf_pkg::STS_SKIPPED, 0));
        else if (tok > tok_limit || tok >= NBUCK || pool_fill >= DEPTH)
          expected_results.push_back(plain_result(lbbf_pkg::STS_REJECTED, 0));
        else begin
          e.request = req;
          e.segment = seg;
          e.tokens  = tok[7:0];
          buckets[tok].push_back(e);
          if (tok > max_len) max_len = tok;
          pool_fill++;
          fresh_cnt++;
          expected_results.push_back(plain_result(lbbf_pkg::STS_ENQUEUED, 0));
        end
      end
      lbbf_pkg::ACT_END: begin
        nb = count_pool_batches();
        w = (wk == 0) ? 1 : wk;
        if (fresh_cnt > 0 && nb < w) cap_val = (fresh_cnt + w - 1) / w;
        fresh_cnt = 0;
        r = plain_result(lbbf_pkg::STS_SUBMIT_DONE, nb);
        r.batches = nb[10:0];
        expected_results.push_back(r);
      end
      lbbf_pkg::ACT_GEN: begin
        n = 0;
        stop = 0;
        for (int l = 0; l < NBUCK && l <= max_len && !stop; l++)
          while (buckets[l].size() > 0) begin
            if (n > 0 && (n + 1) * l > budget_words) begin
              stop = 1;
              break;
            end
            e = buckets[l].pop_front();
            pool_fill--;
            r = '0;
            r.status  = lbbf_pkg::STS_MEMBER;
            r.request = e.request;
            r.segment = e.segment;
            r.tokens  = e.tokens;
            batch.push_back(r);
            n++;
            if ((cap_val != 0 && n >= cap_val) || n >= MAXB) begin
              stop = 1;
              break;
            end
          end
        if (pool_fill == 0) cap_val = 0;
        if (n == 0) expected_results.push_back(plain_result(lbbf_pkg::STS_EMPTY, 0));
        foreach (batch[k]) begin
          batch[k].last    = (k == n - 1);
          batch[k].cap     = sat(cap_val);
          batch[k].pending = sat(pool_fill);
          expected_results.push_back(batch[k]);
        end
      end
      default: begin
        foreach (buckets[l]) buckets[l].delete();
        pool_fill = 0;
        fresh_cnt = 0;
        cap_val = 0;
        max_len = 0;
        expected_results.push_back(plain_result(lbbf_pkg::STS_CLEARED, 0));
      end
    endcase
  endtask

  // sender: hold the command until the transfer, then a random gap;
  // with no gap valid stays up for the next command
  task automatic send_command(logic [1:0] act, logic [15:0] req, logic [11:0] seg,
                              logic [11:0] tok, logic hit, logic [7:0] wk);
    int gap;
    in_chan.valid         <= 1'b1;
    in_chan.action        <= act;
    in_chan.request_id    <= req;
    in_chan.segment_index <= seg;
    in_chan.token_count   <= tok;
    in_chan.cache_hit     <= hit;
    in_chan.worker_count  <= wk;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_command(act, req, seg, tok, hit, wk);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic enqueue(logic [11:0] tok, logic hit = 1'b0);
    send_command(lbbf_pkg::ACT_ENQ, 16'($urandom), 12'($urandom), tok, hit,
                 8'($urandom));
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(lbbf_pkg::reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == lbbf_pkg::REG_MBW) budget_words = val[15:0];
    else tok_limit = val[7:0];
  endtask

  // receiver: a randomly timed wait before each result
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      repeat ($urandom_range(0, 12)) @(posedge clk);
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      out_chan.ready <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    lbbf_pkg::out_item_t x;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result status %0d", $time, out_chan.status);
        errors++;
      end else begin
        x = expected_results.pop_front();
        if (out_chan.status !== x.status || out_chan.out_request !== x.request ||
            out_chan.out_segment !== x.segment || out_chan.out_tokens !== x.tokens ||
            out_chan.last !== x.last || out_chan.sentence_cap !== x.cap ||
            out_chan.batch_count !== x.batches || out_chan.pending_total !== x.pending)
        begin
          $display("%0t expected sts %0d req %h seg %h tok %0d last %b cap %0d bc %0d pend %0d",
                   $time, x.status, x.request, x.segment, x.tokens, x.last, x.cap,
                   x.batches, x.pending);
          $display("%0t actual   sts %0d req %h seg %h tok %0d last %b cap %0d bc %0d pend %0d",
                   $time, out_chan.status, out_chan.out_request, out_chan.out_segment,
                   out_chan.out_tokens, out_chan.last, out_chan.sentence_cap,
                   out_chan.batch_count, out_chan.pending_total);
          errors++;
        end
      end
    end
  end

  // every command and the corners: empty generate, skip, overlong, oversize
  task automatic test_directed();
    send_command(lbbf_pkg::ACT_GEN, 16'hFFFF, 12'hFFF, 12'hFFF, 1'b1, 8'hFF);
    send_command(lbbf_pkg::ACT_END, 16'h0, 12'h0, 12'h0, 1'b0, 8'd0);
    enqueue(12'd0);
    enqueue(12'd255);
    enqueue(12'd256);
    enqueue(12'hFFF);
    enqueue(12'd5, 1'b1);
    send_command(lbbf_pkg::ACT_ENQ, 16'hFFFF, 12'hFFF, 12'd3, 1'b0, 8'hFF);
    send_command(lbbf_pkg::ACT_ENQ, 16'h0000, 12'h000, 12'd3, 1'b0, 8'h00);
    send_command(lbbf_pkg::ACT_END, 16'h0, 12'h0, 12'h0, 1'b0, 8'd255);
    repeat (3) send_command(lbbf_pkg::ACT_GEN, 16'h0, 12'h0, 12'h0, 1'b0, 8'd0);
    send_command(lbbf_pkg::ACT_CLR, 16'hFFFF, 12'hFFF, 12'hFFF, 1'b1, 8'hFF);
    send_command(lbbf_pkg::ACT_GEN, 16'h0, 12'h0, 12'h0, 1'b0, 8'd0);
    wait_drained();
  endtask

  // wide batches hit the MAX_BATCH ceiling with a tiny length
  task automatic test_batch_ceiling();
    write_reg(lbbf_pkg::REG_MBW, 32'd65535);
    repeat (70) enqueue(12'd1);
    send_command(lbbf_pkg::ACT_END, 16'h0, 12'h0, 12'h0, 1'b0, 8'd1);
    repeat (3) send_command(lbbf_pkg::ACT_GEN, 16'h0, 12'h0, 12'h0, 1'b0, 8'd0);
    wait_drained();
  endtask

  // submission rounds with random content, some noise and clears
  task automatic test_random_rounds(int unsigned rounds);
    int unsigned r;
    for (int i = 0; i < rounds; i++) begin
      repeat ($urandom_range(1, 10)) begin
        r = $urandom_range(0, 19);
        if (r == 0) enqueue(12'($urandom), 1'($urandom));
        else if (r == 1) send_command(lbbf_pkg::ACT_CLR, 16'($urandom), 12'($urandom),
                                      12'($urandom), 1'($urandom), 8'($urandom));
        else enqueue(12'($urandom_range(0, 40)), 1'($urandom_range(0, 7) == 0));
      end
      send_command(lbbf_pkg::ACT_END, 16'($urandom), 12'($urandom), 12'($urandom),
                   1'($urandom),
                   8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 6)));
      repeat ($urandom_range(1, 4))
        send_command(lbbf_pkg::ACT_GEN, 16'($urandom), 12'($urandom), 12'($urandom),
                     1'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_settings();
    wait_drained();
    write_reg(lbbf_pkg::REG_MBW, 32'd1);
    write_reg(lbbf_pkg::REG_MAXTOK, 32'd0);
    test_random_rounds(1);
    wait_drained();
    write_reg(lbbf_pkg::REG_MAXTOK, 32'd20);
    write_reg(lbbf_pkg::REG_MBW, 32'd60);
    test_random_rounds(1);
    wait_drained();
    write_reg(lbbf_pkg::REG_MAXTOK, 32'd255);
    write_reg(lbbf_pkg::REG_MBW, 32'd1024);
    test_random_rounds(2);
  endtask

  initial begin
    in_chan.valid         <= 1'b0;
    in_chan.action        <= lbbf_pkg::ACT_ENQ;
    in_chan.request_id    <= '0;
    in_chan.segment_index <= '0;
    in_chan.token_count   <= '0;
    in_chan.cache_hit     <= 1'b0;
    in_chan.worker_count  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_batch_ceiling();
    test_settings();
    wait_drained();
    if (errors == 0 && expected_results.size() == 0)
      $display("tb_length_bucketed_batch_former: done, clean");
    else
      $display("tb_length_bucketed_batch_former: done, errors");
    $finish;
  end
endmodule
